>>> sv/cgfr_pkg.sv
`default_nettype none
package cgfr_pkg;

    localparam logic [10:0] ID_GEAR  = 11'h43F;
    localparam logic [10:0] ID_SPEED = 11'h316;
    localparam logic [10:0] ID_TACHO = 11'h545;

    localparam logic [7:0] SEL_SPORT   = 8'h15;
    localparam logic [7:0] SEL_SIX     = 8'h16;
    localparam logic [7:0] SEL_SEVEN   = 8'h17;
    localparam logic [7:0] SEL_NEUTRAL = 8'h18;

    localparam logic [7:0] GEAR_NONE    = 8'd0;
    localparam logic [7:0] GEAR_SKIP    = 8'd7;
    localparam logic [7:0] GEAR_FIFTH   = 8'd5;
    localparam logic [7:0] GEAR_SIXTH   = 8'd6;
    localparam logic [7:0] CODE_FIFTH   = 8'd9;
    localparam logic [7:0] CODE_SIXTH   = 8'd10;
    localparam logic [7:0] CODE_SPORT   = 8'd5;
    localparam logic [7:0] CODE_SIX     = 8'd6;
    localparam logic [7:0] CODE_SEVEN   = 8'd7;
    localparam logic [7:0] CODE_NEUTRAL = 8'd0;

    localparam int SPEED_W   = 14;
    localparam int TACHO_MAX = 10;
    localparam logic [SPEED_W-1:0] TACHO_STEP = 14'd1000;

    typedef struct packed {
        logic       source_bus;
        logic [10:0] frame_id;
        logic [3:0] frame_length;
        logic [7:0] in_byte_0;
        logic [7:0] in_byte_1;
        logic [7:0] in_byte_2;
        logic [7:0] in_byte_3;
        logic [7:0] in_byte_4;
        logic [7:0] in_byte_5;
        logic [7:0] in_byte_6;
        logic [7:0] in_byte_7;
    } t_in_item;

    typedef struct packed {
        logic       dest_bus;
        logic [10:0] out_id;
        logic [3:0] out_length;
        logic [7:0] out_byte_0;
        logic [7:0] out_byte_1;
        logic [7:0] out_byte_2;
        logic [7:0] out_byte_3;
        logic [7:0] out_byte_4;
        logic [7:0] out_byte_5;
        logic [7:0] out_byte_6;
        logic [7:0] out_byte_7;
    } t_out_item;

endpackage
`default_nettype wire

>>> sv/can_gateway_frame_rewriter_core.sv
// Channel   Valid          Ready          Payload        Dir
// input     i_in_valid     o_in_ready     i_in_item      in
// output    o_out_valid    i_out_ready    o_out_item     out
// config    i_cfg_wr_en    -              i_cfg_wr_data  in
//
// One request per cycle sustained while i_out_ready is high; a request goes
// through the input register, rewrite logic and result register in that order.
// Synchronous active-low reset clears valids, rolling counter, last gear,
// captured speed and the drive logic byte.
// A stalled result holds the result register; the input register still fills,
// and o_in_ready drops only when both are occupied and i_out_ready is low.
`default_nettype none
module can_gateway_frame_rewriter_core (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_ready,
    input  wire cgfr_pkg::t_in_item  i_in_item,
    output logic                     o_out_valid,
    input  wire logic                i_out_ready,
    output cgfr_pkg::t_out_item      o_out_item,
    input  wire logic                i_cfg_wr_en,
    input  wire logic [7:0]          i_cfg_wr_data
);

    logic                w_stage_valid;
    logic                w_can_load;
    logic                w_adv;
    cgfr_pkg::t_in_item  w_stage_item;
    cgfr_pkg::t_out_item w_result;

    assign w_adv = w_stage_valid && w_can_load;

    cgfr_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_ready (o_in_ready),
        .i_item  (i_in_item),
        .i_adv   (w_adv),
        .o_valid (w_stage_valid),
        .o_item  (w_stage_item)
    );

    cgfr_rewrite u_rewrite (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_adv         (w_adv),
        .i_item        (w_stage_item),
        .o_item        (w_result)
    );

    cgfr_out_reg u_out_reg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_adv      (w_adv),
        .i_item     (w_result),
        .o_can_load (w_can_load),
        .o_valid    (o_out_valid),
        .i_ready    (i_out_ready),
        .o_item     (o_out_item)
    );

`ifndef SYNTHESIS
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_out_valid && o_in_ready))
        else $error("valid set after reset");
    a_ready_when_draining: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_ready) |-> o_in_ready)
        else $error("input stalled while output drains");
`endif

endmodule
`default_nettype wire

>>> sv/cgfr_in_reg.sv
`default_nettype none
module cgfr_in_reg (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_ready,
    input  wire cgfr_pkg::t_in_item i_item,
    input  wire logic              i_adv,
    output logic                   o_valid,
    output cgfr_pkg::t_in_item     o_item
);

    logic               r_valid;
    logic               n_valid;
    cgfr_pkg::t_in_item r_item;

    assign o_ready = !r_valid || i_adv;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_comb begin
        n_valid = r_valid;
        if (i_valid && o_ready) begin
            n_valid = 1'b1;
        end else if (i_adv) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_item <= i_item;
        end
    end

endmodule
`default_nettype wire

>>> sv/cgfr_rewrite.sv
`default_nettype none
module cgfr_rewrite (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_wr_en,
    input  wire logic [7:0]         i_cfg_wr_data,
    input  wire logic               i_adv,
    input  wire cgfr_pkg::t_in_item i_item,
    output cgfr_pkg::t_out_item     o_item
);

    logic [7:0]                   r_drive_logic;
    logic [cgfr_pkg::SPEED_W-1:0] r_engine_speed;
    logic [cgfr_pkg::SPEED_W-1:0] n_engine_speed;
    logic [3:0]                   r_gear_counter;
    logic [3:0]                   n_gear_counter;
    logic [7:0]                   r_last_gear;
    logic [7:0]                   n_last_gear;

    logic [7:0]  w_code;
    logic [3:0]  w_tacho;
    logic [18:0] w_speed_x5;
    logic        w_is_gear;
    logic        w_is_speed;
    logic        w_is_tacho;

    function automatic logic [3:0] tacho_digit(input logic [cgfr_pkg::SPEED_W-1:0] speed);
        logic [3:0] q;
        q = 4'd0;
        for (int k = 1; k <= cgfr_pkg::TACHO_MAX; k++) begin
            if (speed >= cgfr_pkg::SPEED_W'(k * int'(cgfr_pkg::TACHO_STEP))) begin
                q = 4'(k);
            end
        end
        return q;
    endfunction

    assign w_is_gear  = (i_item.frame_id == cgfr_pkg::ID_GEAR);
    assign w_is_speed = (i_item.frame_id == cgfr_pkg::ID_SPEED);
    assign w_is_tacho = (i_item.frame_id == cgfr_pkg::ID_TACHO);

    assign w_speed_x5 = {1'b0, i_item.in_byte_3, i_item.in_byte_2, 2'b00}
                      + {3'b000, i_item.in_byte_3, i_item.in_byte_2};
    assign w_tacho    = tacho_digit(r_engine_speed);

    always_comb begin
        w_code = i_item.in_byte_1;
        if (i_item.in_byte_0 != r_last_gear && i_item.in_byte_0 != cgfr_pkg::GEAR_NONE
                && i_item.in_byte_0 != cgfr_pkg::GEAR_SKIP) begin
            if (i_item.in_byte_0 >= 8'd1 && i_item.in_byte_0 <= 8'd4) begin
                w_code = i_item.in_byte_0;
            end else if (i_item.in_byte_0 == cgfr_pkg::GEAR_FIFTH) begin
                w_code = cgfr_pkg::CODE_FIFTH;
            end else if (i_item.in_byte_0 == cgfr_pkg::GEAR_SIXTH) begin
                w_code = cgfr_pkg::CODE_SIXTH;
            end
        end
        unique case (i_item.in_byte_1)
            cgfr_pkg::SEL_SPORT: begin
                w_code = (i_item.in_byte_0 != cgfr_pkg::GEAR_NONE) ? i_item.in_byte_0
                                                                   : cgfr_pkg::CODE_SPORT;
            end
            cgfr_pkg::SEL_SIX:     w_code = cgfr_pkg::CODE_SIX;
            cgfr_pkg::SEL_SEVEN:   w_code = cgfr_pkg::CODE_SEVEN;
            cgfr_pkg::SEL_NEUTRAL: w_code = cgfr_pkg::CODE_NEUTRAL;
            default: ;
        endcase
    end

    always_comb begin
        o_item.dest_bus   = ~i_item.source_bus;
        o_item.out_id     = i_item.frame_id;
        o_item.out_length = i_item.frame_length;
        o_item.out_byte_0 = i_item.in_byte_0;
        o_item.out_byte_1 = i_item.in_byte_1;
        o_item.out_byte_2 = i_item.in_byte_2;
        o_item.out_byte_3 = i_item.in_byte_3;
        o_item.out_byte_4 = i_item.in_byte_4;
        o_item.out_byte_5 = i_item.in_byte_5;
        o_item.out_byte_6 = i_item.in_byte_6;
        o_item.out_byte_7 = i_item.in_byte_7;
        if (w_is_gear) begin
            o_item.out_byte_0 = 8'd0;
            o_item.out_byte_1 = w_code;
            o_item.out_byte_2 = r_drive_logic;
            o_item.out_byte_3 = {~(r_gear_counter ^ w_code[3:0]), r_gear_counter};
            o_item.out_byte_4 = 8'd0;
            o_item.out_byte_5 = 8'd0;
            o_item.out_byte_6 = 8'd0;
            o_item.out_byte_7 = 8'd0;
        end else if (w_is_tacho) begin
            o_item.out_byte_3 = {i_item.in_byte_3[7], w_tacho[2:0], i_item.in_byte_3[3:0]};
        end
    end

    always_comb begin
        n_engine_speed = r_engine_speed;
        n_gear_counter = r_gear_counter;
        n_last_gear    = r_last_gear;
        if (i_adv && w_is_gear) begin
            n_gear_counter = r_gear_counter + 4'd1;
            n_last_gear    = i_item.in_byte_0;
        end
        if (i_adv && w_is_speed) begin
            n_engine_speed = w_speed_x5[18:5];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_drive_logic  <= 8'd0;
            r_engine_speed <= '0;
            r_gear_counter <= 4'd0;
            r_last_gear    <= 8'd0;
        end else begin
            if (i_cfg_wr_en) begin
                r_drive_logic <= i_cfg_wr_data;
            end
            r_engine_speed <= n_engine_speed;
            r_gear_counter <= n_gear_counter;
            r_last_gear    <= n_last_gear;
        end
    end

`ifndef SYNTHESIS
    a_counter_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_adv && w_is_gear) |=> (r_gear_counter == 4'($past(r_gear_counter) + 4'd1)))
        else $error("gear counter did not advance");
    a_last_gear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_adv && w_is_gear) |=> (r_last_gear == $past(i_item.in_byte_0)))
        else $error("last gear not captured");
    a_speed_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_adv && w_is_speed) |=> $stable(r_engine_speed))
        else $error("engine speed changed without a speed request");
`endif

endmodule
`default_nettype wire

>>> sv/cgfr_out_reg.sv
`default_nettype none
module cgfr_out_reg (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_adv,
    input  wire cgfr_pkg::t_out_item i_item,
    output logic                     o_can_load,
    output logic                     o_valid,
    input  wire logic                i_ready,
    output cgfr_pkg::t_out_item      o_item
);

    logic                r_valid;
    logic                n_valid;
    cgfr_pkg::t_out_item r_item;

    assign o_can_load = !r_valid || i_ready;
    assign o_valid    = r_valid;
    assign o_item     = r_item;

    always_comb begin
        n_valid = r_valid;
        if (i_adv) begin
            n_valid = 1'b1;
        end else if (i_ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_item <= i_item;
        end
    end

endmodule
`default_nettype wire
